// ----- rtl/lzssw_pkg.sv -----
// Shared types and constants for the LZSS window expander.
// No dependencies; every other file in rtl/ refers to it by scoped names.

package lzssw_pkg;

  localparam int unsigned SYM_W   = 9;
  localparam int unsigned POS_W   = 12;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned LEN_W   = 7;

  localparam logic [SYM_W-1:0]  CODE_BIAS  = 9'd255;
  localparam logic [BYTE_W-1:0] SPACE_BYTE = 8'h20;

  localparam int unsigned QUEUE_DEPTH = 2;

  typedef struct packed {
    logic              is_match;
    logic [BYTE_W-1:0] lit;
    logic [LEN_W-1:0]  len;
    logic [POS_W-1:0]  pos;
  } token_t;

  typedef struct packed {
    logic   valid;
    token_t tok;
  } queue_head_t;

endpackage

// ----- rtl/lzssw_if.sv -----
// Valid/ready channel interfaces for tokens in and bytes out.
// Depends on lzssw_pkg for field widths.

interface lzssw_in_if;
  logic                             valid;
  logic                             ready;
  logic [lzssw_pkg::SYM_W-1:0]      symbol;
  logic [lzssw_pkg::POS_W-1:0]      position;

  modport source (output valid, output symbol, output position, input ready);
  modport sink (input valid, input symbol, input position, output ready);
endinterface

interface lzssw_out_if;
  logic                             valid;
  logic                             ready;
  logic [lzssw_pkg::BYTE_W-1:0]     data_byte;
  logic                             last;

  modport source (output valid, output data_byte, output last, input ready);
  modport sink (input valid, input data_byte, input last, output ready);
endinterface

// ----- rtl/lzssw_front.sv -----
// Front end: accepts tokens, splits literal from match, works out the
// saturated match length and holds the result in a short queue.
// Depends on lzssw_pkg and lzssw_in_if.

module lzssw_front #(
  parameter int unsigned LOOKAHEAD = 60,
  parameter int unsigned THRESHOLD = 2
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  lzssw_in_if.sink               tok_i,
  output lzssw_pkg::queue_head_t head_o,
  input  logic                   pop_i
);

  localparam int unsigned PTR_W = $clog2(lzssw_pkg::QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(lzssw_pkg::QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(lzssw_pkg::QUEUE_DEPTH);

  lzssw_pkg::token_t entry_q [lzssw_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;

  logic              push;
  logic              pop;
  logic [9:0]        raw_len;
  lzssw_pkg::token_t tok_new;

  always_comb begin
    raw_len = {1'b0, tok_i.symbol} - {1'b0, lzssw_pkg::CODE_BIAS} + 10'(THRESHOLD);
    tok_new.is_match = (tok_i.symbol > {1'b0, lzssw_pkg::CODE_BIAS[lzssw_pkg::BYTE_W-1:0]});
    tok_new.lit      = tok_i.symbol[lzssw_pkg::BYTE_W-1:0];
    tok_new.pos      = tok_i.position;
    if (raw_len > 10'(LOOKAHEAD)) begin
      tok_new.len = lzssw_pkg::LEN_W'(LOOKAHEAD);
    end else begin
      tok_new.len = raw_len[lzssw_pkg::LEN_W-1:0];
    end
  end

  assign tok_i.ready  = (cnt_q != CNT_FULL);
  assign push         = tok_i.valid && tok_i.ready;
  assign pop          = pop_i && (cnt_q != '0);
  assign head_o.valid = (cnt_q != '0);
  assign head_o.tok   = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(lzssw_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(lzssw_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push, pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= tok_new;
    end
  end

endmodule

// ----- rtl/lzssw_back.sv -----
// Back end: ring window memory, copy sequencer and output register.
// Depends on lzssw_pkg and lzssw_out_if.

module lzssw_back #(
  parameter int unsigned WINDOW_SIZE = 4096,
  parameter int unsigned LOOKAHEAD   = 60
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  lzssw_pkg::queue_head_t head_i,
  output logic                  pop_o,
  lzssw_out_if.source           byte_o
);

  localparam int unsigned AW = $clog2(WINDOW_SIZE);
  localparam logic [AW-1:0] WP_RST   = AW'(WINDOW_SIZE - LOOKAHEAD);
  localparam logic [AW:0]   FILL_MAX = (AW + 1)'(WINDOW_SIZE);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_COPY = 1'b1;

  logic [lzssw_pkg::BYTE_W-1:0] mem [WINDOW_SIZE];
  logic [lzssw_pkg::BYTE_W-1:0] rdata_q;
  logic                         rvalid_q;

  logic                         state_q, state_d;
  logic [AW-1:0]                wp_q, wp_d;
  logic [AW-1:0]                src_q, src_d;
  logic [lzssw_pkg::LEN_W-1:0]  rem_q, rem_d;
  logic [AW:0]                  fill_q, fill_d;

  logic                         out_valid_q;
  logic [lzssw_pkg::BYTE_W-1:0] out_byte_q;
  logic                         out_last_q;

  logic                         out_free;
  logic                         we;
  logic [lzssw_pkg::BYTE_W-1:0] wdata;
  logic                         re;
  logic [AW-1:0]                raddr;
  logic                         rd_hit;
  logic                         emit;
  logic                         emit_last;
  logic [AW-1:0]                src_new;
  logic [AW-1:0]                rd_off;
  logic [lzssw_pkg::BYTE_W-1:0] rbyte;

  assign out_free = !out_valid_q || byte_o.ready;
  assign src_new  = wp_q - AW'(head_i.tok.pos) - 1'b1;
  assign rbyte    = rvalid_q ? rdata_q : lzssw_pkg::SPACE_BYTE;

  always_comb begin
    state_d   = state_q;
    src_d     = src_q;
    rem_d     = rem_q;
    pop_o     = 1'b0;
    we        = 1'b0;
    wdata     = rbyte;
    re        = 1'b0;
    raddr     = src_q;
    emit      = 1'b0;
    emit_last = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (head_i.valid) begin
          if (head_i.tok.is_match) begin
            pop_o   = 1'b1;
            re      = 1'b1;
            raddr   = src_new;
            src_d   = src_new + 1'b1;
            rem_d   = head_i.tok.len;
            state_d = ST_COPY;
          end else if (out_free) begin
            pop_o     = 1'b1;
            we        = 1'b1;
            wdata     = head_i.tok.lit;
            emit      = 1'b1;
            emit_last = 1'b1;
          end
        end
      end
      ST_COPY: begin
        if (out_free) begin
          we        = 1'b1;
          emit      = 1'b1;
          emit_last = (rem_q == lzssw_pkg::LEN_W'(1));
          rem_d     = rem_q - 1'b1;
          if (rem_q == lzssw_pkg::LEN_W'(1)) begin
            state_d = ST_IDLE;
          end else begin
            re    = 1'b1;
            raddr = src_q;
            src_d = src_q + 1'b1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    wp_d   = we ? wp_q + 1'b1 : wp_q;
    fill_d = (we && fill_q != FILL_MAX) ? fill_q + 1'b1 : fill_q;
    rd_off = raddr - WP_RST;
    rd_hit = ({1'b0, rd_off} < fill_q) || (we && wp_q == raddr);
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wp_q] <= wdata;
    end
    if (re) begin
      rdata_q <= (we && wp_q == raddr) ? wdata : mem[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wp_q        <= WP_RST;
      src_q       <= '0;
      rem_q       <= '0;
      fill_q      <= '0;
      rvalid_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      wp_q     <= wp_d;
      src_q    <= src_d;
      rem_q    <= rem_d;
      fill_q   <= fill_d;
      if (re) begin
        rvalid_q <= rd_hit;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (byte_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_byte_q <= wdata;
      out_last_q <= emit_last;
    end
  end

  assign byte_o.valid     = out_valid_q;
  assign byte_o.data_byte = out_byte_q;
  assign byte_o.last      = out_last_q;

endmodule

// ----- rtl/lzss_window_expander_unit.sv -----
// Top level of the LZSS window expander: front end, token queue, back end.
// Depends on lzssw_pkg, lzssw_if, lzssw_front and lzssw_back.
//
//   channel  dir  handshake        item
//   tok_i    in   valid / ready    symbol[8:0], position[11:0]
//   byte_o   out  valid / ready    data_byte[7:0], last
//
// A literal is written and emitted without a window read; a match
// first launches a window read, then yields one byte per cycle while the
// output register is free, paced by the window memory's single read port.
// Reset needs no clearing pass: a fill count marks written window entries
// and unwritten ones read as space.
// The two-entry queue keeps taking tokens until full while the back end or
// the output register is stalled.

module lzss_window_expander_unit #(
  parameter int unsigned WINDOW_SIZE = 4096,
  parameter int unsigned LOOKAHEAD   = 60,
  parameter int unsigned THRESHOLD   = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lzssw_in_if.sink    tok_i,
  lzssw_out_if.source byte_o
);

  lzssw_pkg::queue_head_t head;
  logic                   pop;

  lzssw_front #(
    .LOOKAHEAD (LOOKAHEAD),
    .THRESHOLD (THRESHOLD)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tok_i  (tok_i),
    .head_o (head),
    .pop_i  (pop)
  );

  lzssw_back #(
    .WINDOW_SIZE (WINDOW_SIZE),
    .LOOKAHEAD   (LOOKAHEAD)
  ) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .pop_o  (pop),
    .byte_o (byte_o)
  );

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 100ps
// Testbench for lzss_window_expander_unit: drives decoded LZSS tokens and checks every byte.
// Depends on lzssw_pkg, lzssw_if and the RTL top level; keeps its own window image.

module tb;

  localparam int unsigned WINDOW_SIZE = 4096;
  localparam int unsigned LOOKAHEAD   = 60;
  localparam int unsigned THRESHOLD   = 2;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;

  typedef struct packed {
    logic [lzssw_pkg::BYTE_W-1:0] data;
    logic                         last;
  } out_byte_t;

  logic clk_i;
  logic rst_ni;

  lzssw_in_if  tok_if ();
  lzssw_out_if byte_if ();

  lzss_window_expander_unit #(
    .WINDOW_SIZE(WINDOW_SIZE),
    .LOOKAHEAD  (LOOKAHEAD),
    .THRESHOLD  (THRESHOLD)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .tok_i (tok_if),
    .byte_o(byte_if)
  );

  logic [lzssw_pkg::BYTE_W-1:0] window_img [WINDOW_SIZE];
  logic [lzssw_pkg::POS_W-1:0]  wr_ptr;
  out_byte_t                    exp_bytes [$];

  int unsigned src_idle_pct;
  int unsigned sink_idle_pct;
  int unsigned hold_left;
  int unsigned mismatches;
  int unsigned run_cycles;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    run_cycles++;
    if (run_cycles >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    if (mismatches < 40) $display("ERROR @%0t: %s", $time, msg);
    mismatches++;
  endtask

  // Expand one token against the window image and queue the bytes it yields.
  task automatic predict_token(input logic [lzssw_pkg::SYM_W-1:0] sym,
                               input logic [lzssw_pkg::POS_W-1:0] pos);
    int unsigned                  len;
    logic [lzssw_pkg::POS_W-1:0]  src;
    logic [lzssw_pkg::BYTE_W-1:0] b;
    out_byte_t                    ob;
    if (sym <= lzssw_pkg::CODE_BIAS) begin
      b = sym[lzssw_pkg::BYTE_W-1:0];
      window_img[wr_ptr] = b;
      wr_ptr = wr_ptr + 1'b1;
      ob.data = b;
      ob.last = 1'b1;
      exp_bytes.push_back(ob);
    end else begin
      len = int'(sym) - int'(lzssw_pkg::CODE_BIAS) + THRESHOLD;
      if (len > LOOKAHEAD) len = LOOKAHEAD;
      src = wr_ptr - pos - 1'b1;
      for (int unsigned n = 0; n < len; n++) begin
        b = window_img[src];
        window_img[wr_ptr] = b;
        wr_ptr = wr_ptr + 1'b1;
        src = src + 1'b1;
        ob.data = b;
        ob.last = (n + 1 == len);
        exp_bytes.push_back(ob);
      end
    end
  endtask

  task automatic send_token(input logic [lzssw_pkg::SYM_W-1:0] sym,
                            input logic [lzssw_pkg::POS_W-1:0] pos);
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      tok_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    tok_if.valid    <= 1'b1;
    tok_if.symbol   <= sym;
    tok_if.position <= pos;
    @(posedge clk_i);
    while (!tok_if.ready) @(posedge clk_i);
    predict_token(sym, pos);
  endtask

  task automatic random_token(output logic [lzssw_pkg::SYM_W-1:0] sym,
                              output logic [lzssw_pkg::POS_W-1:0] pos);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 45)      sym = lzssw_pkg::SYM_W'($urandom_range(255));
    else if (r < 85) sym = lzssw_pkg::SYM_W'($urandom_range(266, 256));
    else if (r < 95) sym = lzssw_pkg::SYM_W'($urandom_range(313, 256));
    else             sym = lzssw_pkg::SYM_W'($urandom_range(511, 314));
    if ($urandom_range(99) < 70) pos = lzssw_pkg::POS_W'($urandom_range(63));
    else                         pos = lzssw_pkg::POS_W'($urandom_range(4095));
  endtask

  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      byte_if.ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      byte_if.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    out_byte_t ob;
    if (rst_ni && byte_if.valid && byte_if.ready) begin
      if (exp_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %02h last %0b",
                                  byte_if.data_byte, byte_if.last));
      end else begin
        ob = exp_bytes.pop_front();
        if (byte_if.data_byte !== ob.data)
          report_mismatch($sformatf("data_byte %02h, expected %02h",
                                    byte_if.data_byte, ob.data));
        if (byte_if.last !== ob.last)
          report_mismatch($sformatf("last %0b, expected %0b", byte_if.last, ob.last));
      end
    end
  end

  task automatic test_directed();
    src_idle_pct  = 9;
    sink_idle_pct = 83;
    send_token(9'd256, 12'd0);
    send_token(9'd0, 12'd0);
    send_token(9'd255, 12'd4095);
    send_token(9'h0A5, 12'hAAA);
    send_token(9'h05A, 12'h555);
    send_token(9'd257, 12'd0);
    send_token(9'd258, 12'd3);
    send_token(9'd313, 12'd9);
    send_token(9'd314, 12'd2);
    send_token(9'd511, 12'd4095);
    send_token(9'd300, 12'd4095);
    send_token(9'd260, 12'hAAA);
    send_token(9'd261, 12'h555);
    send_token(9'd313, 12'd0);
    send_token(9'd256, 12'd4000);
    send_token(9'h1FF, 12'd1);
  endtask

  task automatic test_random(input int unsigned src_pct, input int unsigned sink_pct,
                             input int unsigned count);
    logic [lzssw_pkg::SYM_W-1:0] sym;
    logic [lzssw_pkg::POS_W-1:0] pos;
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    repeat (count) begin
      random_token(sym, pos);
      send_token(sym, pos);
    end
  endtask

  // Hold the output off while tokens keep coming, so the queue fills and input stalls.
  task automatic test_backpressure();
    logic [lzssw_pkg::SYM_W-1:0] sym;
    logic [lzssw_pkg::POS_W-1:0] pos;
    src_idle_pct  = 0;
    sink_idle_pct = 9;
    hold_left     = 400;
    repeat (30) begin
      random_token(sym, pos);
      send_token(sym, pos);
    end
  endtask

  initial begin
    rst_ni          = 1'b0;
    tok_if.valid    = 1'b0;
    tok_if.symbol   = '0;
    tok_if.position = '0;
    byte_if.ready   = 1'b0;
    src_idle_pct    = 0;
    sink_idle_pct   = 0;
    hold_left       = 0;
    mismatches      = 0;
    run_cycles      = 0;
    foreach (window_img[i]) window_img[i] = lzssw_pkg::SPACE_BYTE;
    wr_ptr = lzssw_pkg::POS_W'(WINDOW_SIZE - LOOKAHEAD);
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_random(9, 83, 120);
    test_random(83, 9, 120);
    test_backpressure();
    test_random(0, 0, 100);

    @(negedge clk_i);
    tok_if.valid <= 1'b0;
    while (exp_bytes.size() != 0) @(posedge clk_i);
    repeat (LOOKAHEAD + 20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
